// ----- src/lpht_pkg.sv -----
package lpht_pkg;

  // Table geometry and key shape.
  localparam int SLOTS     = 32;
  localparam int KEY_BYTES = 8;

  // Field widths of the register and of one input and one result.
  localparam int CFG_W     = 6;
  localparam int KEY_W     = 64;
  localparam int STATUS_W  = 3;
  localparam int SLOT_FW   = 5;
  localparam int CMP_W     = 6;

  // Internal widths derived from the geometry.
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SUM_W     = $clog2(KEY_BYTES * 255 + 1);
  localparam int STEP_W    = $clog2(((SUM_W > KEY_BYTES) ? SUM_W : KEY_BYTES) + 1);

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(10);

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_MOD,
    S_HOME,
    S_PROBE,
    S_CHECK,
    S_DONE
  } state_e;

  // Controls for the hash datapath.
  typedef struct packed {
    logic load;
    logic sum_step;
    logic mod_step;
  } hash_ctl_t;

  // One access to the slot store.
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [SLOT_W-1:0] addr;
  } store_req_t;

  // Mask that keeps only the key bytes in use.
  function automatic logic [KEY_W-1:0] key_mask();
    logic [KEY_W-1:0] m;
    m = '0;
    for (int b = 0; b < KEY_W / 8; b++) begin
      if (b < KEY_BYTES) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ----- src/lpht_hash.sv -----
module lpht_hash (
  input  logic                                clk_i,
  input  lpht_pkg::hash_ctl_t                 ctl_i,
  input  logic [lpht_pkg::KEY_W-1:0]          key_i,
  input  logic [lpht_pkg::CFG_W-1:0]          size_i,
  output logic [lpht_pkg::SLOT_W-1:0]         home_o
);

  logic [lpht_pkg::KEY_W-1:0] key_q;
  logic [lpht_pkg::SUM_W-1:0] sum_q;
  logic [lpht_pkg::CFG_W-1:0] rem_q;
  logic [lpht_pkg::CFG_W:0]   rem_shift;
  logic [lpht_pkg::CFG_W:0]   rem_sub;

  // One restoring division step: bring in the next sum bit, subtract if it fits.
  assign rem_shift = {rem_q, sum_q[lpht_pkg::SUM_W-1]};
  assign rem_sub   = rem_shift - {1'b0, size_i};

  // Byte accumulation first, then the remainder one bit per cycle.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      key_q <= key_i;
      sum_q <= '0;
      rem_q <= '0;
    end else if (ctl_i.sum_step) begin
      sum_q <= sum_q + lpht_pkg::SUM_W'(key_q[7:0]);
      key_q <= key_q >> 8;
    end else if (ctl_i.mod_step) begin
      sum_q <= sum_q << 1;
      if (rem_shift >= {1'b0, size_i}) begin
        rem_q <= rem_sub[lpht_pkg::CFG_W-1:0];
      end else begin
        rem_q <= rem_shift[lpht_pkg::CFG_W-1:0];
      end
    end
  end

  assign home_o = lpht_pkg::SLOT_W'(rem_q);

endmodule

// ----- src/lpht_store.sv -----
module lpht_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lpht_pkg::store_req_t         req_i,
  input  logic [lpht_pkg::KEY_W-1:0]   wdata_i,
  output logic                         used_o,
  output logic [lpht_pkg::KEY_W-1:0]   rdata_o
);

  logic [lpht_pkg::KEY_W-1:0] mem [lpht_pkg::SLOTS];
  logic [lpht_pkg::SLOTS-1:0] used_q;
  logic [lpht_pkg::KEY_W-1:0] rdata_q;

  // Key memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem[req_i.addr] <= wdata_i;
    end
    if (req_i.rd) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  // Occupancy bits, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (req_i.wr) begin
      used_q[req_i.addr] <= 1'b1;
    end
  end

  assign used_o  = used_q[req_i.addr];
  assign rdata_o = rdata_q;

endmodule

// ----- src/linear_probe_hash_table_top.sv -----
// Channel   Direction  Transaction carries
// s_axis    in         tuser: kind; tdata: key
// m_axis    out        tdata: status, slot, compares
// cfg       in         data: table_size
//
// One item passes through the byte sum, the remainder and the home slot, then makes
// p probes (1 to the table size); a probe that ends at an empty slot skips the
// compare. The byte adder, the one-bit-per-cycle remainder unit and the single key
// memory port (one read, then one compare, per probe of a used slot) do this work.
// Reset clears the occupancy bits and sets table_size to 10; no clearing pass.
// s_axis_tready is high only while the block is idle; a finished result waits in
// the output register, and the next result waits in S_DONE until it is taken.
module linear_probe_hash_table_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [lpht_pkg::KEY_W-1:0]         s_axis_tdata,   // [63:0] key
  input  logic                               s_axis_tuser,   // [0] kind
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [15:0]                        m_axis_tdata,   // [2:0] status, [7:3] slot,
                                                             // [13:8] compares, [15:14] zero
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lpht_pkg::CFG_W-1:0]         cfg_data_i
);

  lpht_pkg::state_e             state_q, state_d;
  lpht_pkg::hash_ctl_t          hash_ctl;
  lpht_pkg::store_req_t         store_req;

  logic [lpht_pkg::CFG_W-1:0]   size_q;
  logic [lpht_pkg::CFG_W-1:0]   eff_size;
  logic                         search_q;
  logic [lpht_pkg::KEY_W-1:0]   key_q;
  logic [lpht_pkg::KEY_W-1:0]   key_in;
  logic [lpht_pkg::STEP_W-1:0]  step_q;
  logic [lpht_pkg::SLOT_W-1:0]  pos_q;
  logic [lpht_pkg::SLOT_W-1:0]  pos_next;
  logic [lpht_pkg::SLOT_W-1:0]  home;
  logic [lpht_pkg::CMP_W-1:0]   cmp_q;
  logic [lpht_pkg::CMP_W-1:0]   cmp_inc;
  lpht_pkg::status_e            res_status_q;
  logic [lpht_pkg::SLOT_FW-1:0] res_slot_q;
  logic                         used;
  logic [lpht_pkg::KEY_W-1:0]   rdata;
  logic                         in_fire;
  logic                         out_free;
  logic                         sum_last;
  logic                         mod_last;
  logic                         key_equal;
  logic                         probed_all;
  logic                         out_valid_q;
  logic [15:0]                  out_data_q;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign key_in   = s_axis_tdata & lpht_pkg::key_mask();

  // Effective table size: zero counts as one, and it never exceeds the slots.
  always_comb begin
    if (size_q == '0) begin
      eff_size = lpht_pkg::CFG_W'(1);
    end else if (32'(size_q) > lpht_pkg::SLOTS) begin
      eff_size = lpht_pkg::CFG_W'(lpht_pkg::SLOTS);
    end else begin
      eff_size = size_q;
    end
  end

  // Configuration register; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= lpht_pkg::SIZE_RESET;
    end else if (cfg_valid_i) begin
      size_q <= cfg_data_i;
    end
  end

  // Sequence conditions.
  assign sum_last   = (32'(step_q) == lpht_pkg::KEY_BYTES - 1);
  assign mod_last   = (32'(step_q) == lpht_pkg::SUM_W - 1);
  assign cmp_inc    = cmp_q + 1'b1;
  assign key_equal  = (rdata == key_q);
  assign probed_all = (cmp_inc == eff_size);
  assign pos_next   = (32'(pos_q) + 1 == 32'(eff_size)) ? '0 : pos_q + 1'b1;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lpht_pkg::S_IDLE:  if (in_fire) state_d = lpht_pkg::S_SUM;
      lpht_pkg::S_SUM:   if (sum_last) state_d = lpht_pkg::S_MOD;
      lpht_pkg::S_MOD:   if (mod_last) state_d = lpht_pkg::S_HOME;
      lpht_pkg::S_HOME:  state_d = lpht_pkg::S_PROBE;
      lpht_pkg::S_PROBE: state_d = used ? lpht_pkg::S_CHECK : lpht_pkg::S_DONE;
      lpht_pkg::S_CHECK: state_d = (key_equal || probed_all) ? lpht_pkg::S_DONE
                                                             : lpht_pkg::S_PROBE;
      lpht_pkg::S_DONE:  if (out_free) state_d = lpht_pkg::S_IDLE;
      default:           state_d = lpht_pkg::S_IDLE;
    endcase
  end

  // Output logic: handshake, hash unit and store controls.
  always_comb begin
    s_axis_tready     = 1'b0;
    hash_ctl          = '0;
    store_req.rd      = 1'b0;
    store_req.wr      = 1'b0;
    store_req.addr    = pos_q;
    unique case (state_q)
      lpht_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        hash_ctl.load = in_fire;
      end
      lpht_pkg::S_SUM:   hash_ctl.sum_step = 1'b1;
      lpht_pkg::S_MOD:   hash_ctl.mod_step = 1'b1;
      lpht_pkg::S_PROBE: begin
        store_req.rd = used;
        store_req.wr = !used && !search_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpht_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers of one item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (state_q == lpht_pkg::S_IDLE || sum_last && state_q == lpht_pkg::S_SUM) begin
      step_q <= '0;
    end else if (state_q == lpht_pkg::S_SUM || state_q == lpht_pkg::S_MOD) begin
      step_q <= step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      lpht_pkg::S_IDLE: begin
        if (in_fire) begin
          search_q <= s_axis_tuser;
          key_q    <= key_in;
          cmp_q    <= '0;
        end
      end
      lpht_pkg::S_HOME: pos_q <= home;
      lpht_pkg::S_PROBE: begin
        // An empty slot ends the probe: store here or report a miss.
        if (!used) begin
          if (search_q) begin
            res_status_q <= lpht_pkg::ST_NOT_FOUND;
            res_slot_q   <= '0;
          end else begin
            res_status_q <= lpht_pkg::ST_INSERTED;
            res_slot_q   <= lpht_pkg::SLOT_FW'(pos_q);
          end
        end
      end
      lpht_pkg::S_CHECK: begin
        cmp_q <= cmp_inc;
        if (key_equal) begin
          res_status_q <= search_q ? lpht_pkg::ST_FOUND : lpht_pkg::ST_DUPLICATE;
          res_slot_q   <= search_q ? lpht_pkg::SLOT_FW'(pos_q) : '0;
        end else if (probed_all) begin
          res_status_q <= search_q ? lpht_pkg::ST_NOT_FOUND : lpht_pkg::ST_FULL;
          res_slot_q   <= '0;
        end else begin
          pos_q <= pos_next;
        end
      end
      default: ;
    endcase
  end

  // Output register: loaded from S_DONE, held until the transaction completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == lpht_pkg::S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lpht_pkg::S_DONE && out_free) begin
      out_data_q <= {2'b00, cmp_q, res_slot_q, res_status_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  lpht_hash u_hash (
    .clk_i  (clk_i),
    .ctl_i  (hash_ctl),
    .key_i  (key_in),
    .size_i (eff_size),
    .home_o (home)
  );

  lpht_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (store_req),
    .wdata_i (key_q),
    .used_o  (used),
    .rdata_o (rdata)
  );

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;

  // Kinds of request carried in tuser.
  localparam bit KIND_INSERT = 1'b0;
  localparam bit KIND_SEARCH = 1'b1;

  localparam int RANDOM_ITEMS  = 1080;
  localparam int IDLE_SETTLE   = 8;
  localparam int END_SETTLE    = 120;
  localparam int LONG_HOLD     = 500;
  localparam int POOL_DEPTH    = 48;
  localparam int CYCLE_LIMIT   = 1000000;

  // One expected lookup outcome, with the same fields as a result.
  typedef struct packed {
    lpht_pkg::status_e               status;
    logic [lpht_pkg::SLOT_FW-1:0]    slot;
    logic [lpht_pkg::CMP_W-1:0]      compares;
  } lookup_result_t;

  // Mirror of the hash table plus the queue of outcomes still owed by the block.
  class hash_table_scoreboard;
    logic [lpht_pkg::CFG_W-1:0] size_reg;
    logic [lpht_pkg::KEY_W-1:0] stored_key [lpht_pkg::SLOTS];
    bit                         occupied   [lpht_pkg::SLOTS];
    lookup_result_t             owed_q[$];
    int                         failures;
    int                         checked;
    int                         status_tally [5];

    function new();
      size_reg = lpht_pkg::SIZE_RESET;
      failures = 0;
      checked  = 0;
      for (int i = 0; i < lpht_pkg::SLOTS; i++) begin
        stored_key[i] = '0;
        occupied[i]   = 1'b0;
      end
      for (int i = 0; i < 5; i++) begin
        status_tally[i] = 0;
      end
    endfunction

    function void write_size(logic [lpht_pkg::CFG_W-1:0] value);
      size_reg = value;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Work out the outcome of one accepted request and update the mirror.
    function void note_request(bit kind, logic [lpht_pkg::KEY_W-1:0] raw_key);
      logic [lpht_pkg::KEY_W-1:0] kmask;
      logic [lpht_pkg::KEY_W-1:0] k;
      int unsigned      span;
      int unsigned      sum;
      int unsigned      home;
      int unsigned      pos;
      int unsigned      cmp;
      lookup_result_t   r;
      kmask = (lpht_pkg::KEY_BYTES >= 8) ? '1
                                         : ((64'd1 << (8 * lpht_pkg::KEY_BYTES)) - 64'd1);
      k = raw_key & kmask;
      span = (size_reg == 0) ? 1
                             : ((size_reg > lpht_pkg::SLOTS) ? lpht_pkg::SLOTS : size_reg);
      sum = 0;
      for (int b = 0; b < 8; b++) begin
        sum += k[8*b +: 8];
      end
      home = sum % span;
      r.status = (kind == KIND_SEARCH) ? lpht_pkg::ST_NOT_FOUND : lpht_pkg::ST_FULL;
      r.slot = '0;
      cmp = 0;
      for (int i = 0; i < span; i++) begin
        pos = (home + i) % span;
        if (!occupied[pos]) begin
          if (kind == KIND_INSERT) begin
            occupied[pos]   = 1'b1;
            stored_key[pos] = k;
            r.status = lpht_pkg::ST_INSERTED;
            r.slot   = pos[lpht_pkg::SLOT_FW-1:0];
          end else begin
            r.status = lpht_pkg::ST_NOT_FOUND;
          end
          break;
        end
        cmp++;
        if (stored_key[pos] == k) begin
          if (kind == KIND_SEARCH) begin
            r.status = lpht_pkg::ST_FOUND;
            r.slot   = pos[lpht_pkg::SLOT_FW-1:0];
          end else begin
            r.status = lpht_pkg::ST_DUPLICATE;
          end
          break;
        end
      end
      r.compares = cmp[lpht_pkg::CMP_W-1:0];
      status_tally[r.status]++;
      owed_q.push_back(r);
    endfunction

    // Compare one result transaction with the oldest owed outcome.
    function void check_result(logic [15:0] word);
      lookup_result_t want;
      logic [2:0]                   got_status;
      logic [lpht_pkg::SLOT_FW-1:0] got_slot;
      logic [lpht_pkg::CMP_W-1:0]   got_cmp;
      logic [1:0]                   got_pad;
      bit                           bad;
      got_status = word[2:0];
      got_slot   = word[7:3];
      got_cmp    = word[13:8];
      got_pad    = word[15:14];
      if (owed_q.size() == 0) begin
        if (failures < 10) begin
          $display("Unexpected result transaction, data %h", word);
        end
        failures++;
        return;
      end
      want = owed_q.pop_front();
      bad = 1'b0;
      if (got_status !== want.status) bad = 1'b1;
      if (got_slot !== want.slot) bad = 1'b1;
      if (got_cmp !== want.compares) bad = 1'b1;
      if (got_pad !== 2'b00) bad = 1'b1;
      if (bad) begin
        if (failures < 10) begin
          // Fields are listed as status/slot/compares.
          $display("Result %0d mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d pad %b",
                   checked, want.status, want.slot, want.compares,
                   got_status, got_slot, got_cmp, got_pad);
        end
        failures++;
      end
      checked++;
    endfunction
  endclass

  // Block ports; the inputs are driven to known values from time zero.
  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [lpht_pkg::KEY_W-1:0]   s_axis_tdata  = '0;
  logic                         s_axis_tuser  = 1'b0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [15:0]                  m_axis_tdata;
  logic                         cfg_valid_i   = 1'b0;
  logic                         cfg_ready_o;
  logic [lpht_pkg::CFG_W-1:0]   cfg_data_i    = '0;

  hash_table_scoreboard         sb;
  logic [lpht_pkg::KEY_W-1:0]   key_pool[$];
  int                           results_seen  = 0;
  int                           requests_sent = 0;
  int                           sizes_written = 0;
  int                           burst_left    = 0;
  int                           cycle_count   = 0;

  linear_probe_hash_table_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
      results_seen++;
    end
  end

  // Receiver: segments of varying stall density, plus two long hold-offs.
  initial begin
    int seg_left;
    int stall_pct;
    int hold_left;
    int next_hold;
    seg_left  = 0;
    stall_pct = 0;
    hold_left = 0;
    next_hold = 150;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && next_hold > 0 && results_seen >= next_hold) begin
        hold_left = LONG_HOLD;
        next_hold = (next_hold < 700) ? 700 : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(200, 10);
          case ($urandom_range(3, 0))
            0: stall_pct = 0;
            1: stall_pct = 30;
            2: stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        seg_left--;
        m_axis_tready <= ($urandom_range(99, 0) >= stall_pct);
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results owed", cycle_count, sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

  // Offer one request and hold it until the block takes it.
  task automatic send_request(input bit kind, input logic [lpht_pkg::KEY_W-1:0] key);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= key;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(kind, key);
    requests_sent++;
  endtask

  // Stop offering and let every owed result come back.
  task automatic wait_for_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (IDLE_SETTLE) @(posedge clk_i);
  endtask

  task automatic set_table_size(input logic [lpht_pkg::CFG_W-1:0] value);
    wait_for_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_size(value);
    sizes_written++;
    cfg_valid_i <= 1'b0;
  endtask

  // Either a fully random word or a short printable string.
  function automatic logic [lpht_pkg::KEY_W-1:0] fresh_key();
    logic [lpht_pkg::KEY_W-1:0] k;
    int                         len;
    k = '0;
    if ($urandom_range(1, 0) == 0) begin
      k = {$urandom, $urandom};
    end else begin
      len = $urandom_range(8, 1);
      for (int b = 0; b < len; b++) begin
        k[8*b +: 8] = 8'($urandom_range(8'h7E, 8'h20));
      end
    end
    return k;
  endfunction

  // Mostly reuse known keys so that duplicates and hits are common; swapping two
  // bytes keeps the home slot and, when the bytes differ, makes a new key that must probe.
  task automatic pick_request(output bit kind, output logic [lpht_pkg::KEY_W-1:0] key);
    int unsigned roll;
    int unsigned a;
    int unsigned b;
    logic [7:0]  tmp;
    roll = $urandom_range(99, 0);
    kind = ($urandom_range(1, 0) == 1) ? KIND_SEARCH : KIND_INSERT;
    if (key_pool.size() == 0 || roll < 25) begin
      key = fresh_key();
    end else begin
      key = key_pool[$urandom_range(key_pool.size() - 1, 0)];
      if (roll < 45) begin
        a = $urandom_range(7, 0);
        b = $urandom_range(7, 0);
        tmp = key[8*a +: 8];
        key[8*a +: 8] = key[8*b +: 8];
        key[8*b +: 8] = tmp;
      end
    end
    if (key_pool.size() < POOL_DEPTH) begin
      key_pool.push_back(key);
    end else begin
      key_pool[$urandom_range(POOL_DEPTH - 1, 0)] = key;
    end
  endtask

  // Random requests sent in bursts, with gaps between them unless gapless is set.
  task automatic run_random_phase(input int count, input bit gapless);
    bit                         kind;
    logic [lpht_pkg::KEY_W-1:0] key;
    int                         gap;
    for (int n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(20, 1);
        gap = gapless ? 0 : $urandom_range(15, 0);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
      pick_request(kind, key);
      send_request(kind, key);
    end
  endtask

  // Main sequence.
  initial begin
    int phase_sizes[] = '{2, 3, 5, 7, 10, 12, 16, 20, 24, 28, 31, 32, 40, 63, 0, 1, 4, 17, 32};
    int per_phase;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset size of ten: empty search, insert, duplicate,
    // hit, collisions on the home slot and a probe that wraps around.
    send_request(KIND_SEARCH, 64'h0);
    send_request(KIND_INSERT, 64'h0);
    send_request(KIND_INSERT, 64'h0);
    send_request(KIND_SEARCH, 64'h0);
    send_request(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(KIND_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(KIND_INSERT, 64'h0000_0000_0000_000A);
    send_request(KIND_INSERT, 64'h0A00_0000_0000_0000);
    send_request(KIND_SEARCH, 64'h0000_0000_0005_0005);
    send_request(KIND_INSERT, 64'h9);
    send_request(KIND_INSERT, 64'h13);
    // Fill the remaining slots, then hit the full table with both kinds.
    send_request(KIND_INSERT, 64'h6);
    send_request(KIND_INSERT, 64'h7);
    send_request(KIND_INSERT, 64'h8);
    send_request(KIND_INSERT, 64'h5);
    send_request(KIND_INSERT, 64'hF);
    send_request(KIND_SEARCH, 64'hF);

    // A size of zero behaves as a single slot.
    set_table_size(6'd0);
    send_request(KIND_SEARCH, 64'h0);
    send_request(KIND_INSERT, 64'h5);
    send_request(KIND_SEARCH, 64'h5);

    // An oversized setting is clamped; stored keys are not rehashed.
    set_table_size(6'd63);
    send_request(KIND_INSERT, 64'h20);
    send_request(KIND_SEARCH, 64'h13);

    // Random part, one phase per table size.
    per_phase = RANDOM_ITEMS / phase_sizes.size();
    foreach (phase_sizes[p]) begin
      set_table_size(phase_sizes[p][lpht_pkg::CFG_W-1:0]);
      run_random_phase(per_phase, (p % 4) == 3);
    end

    wait_for_idle();
    repeat (END_SETTLE) @(posedge clk_i);
    $display("Covered %0d requests over %0d size settings; %0d results checked, %0d failures.",
             requests_sent, sizes_written, sb.checked, sb.failures);
    $display("Outcomes: %0d inserted, %0d duplicate, %0d full, %0d found, %0d not found.",
             sb.status_tally[lpht_pkg::ST_INSERTED], sb.status_tally[lpht_pkg::ST_DUPLICATE],
             sb.status_tally[lpht_pkg::ST_FULL], sb.status_tally[lpht_pkg::ST_FOUND],
             sb.status_tally[lpht_pkg::ST_NOT_FOUND]);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
